// ===== src/fsc_pkg.sv =====
package fsc_pkg;

  localparam int DATA_W     = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int MAT_DEPTH  = 16;
  localparam int PL_DEPTH   = 24;
  localparam int NUM_PLANES = 6;

  localparam logic [1:0] KIND_ROW     = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_TEST    = 2'd2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    PM_PLUS  = 2'd0,
    PM_MINUS = 2'd1,
    PM_ALONE = 2'd2
  } pmode_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] elem_0;
    logic signed [DATA_W-1:0] elem_1;
    logic signed [DATA_W-1:0] elem_2;
    logic signed [DATA_W-1:0] elem_3;
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic signed [DATA_W-1:0] center_z;
    logic [30:0]              radius;
  } req_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] done_kind;
  } rsp_t;

  // Column combined with column 3 for each plane: left, right, top, bottom, near, far.
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    logic [1:0] c;
    unique case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic pmode_t plane_mode(input logic [2:0] p);
    pmode_t m;
    unique case (p)
      3'd0, 3'd3: m = PM_PLUS;
      3'd4:       m = PM_ALONE;
      default:    m = PM_MINUS;
    endcase
    return m;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] x);
    logic signed [DATA_W-1:0] r;
    if (x[DATA_W] != x[DATA_W-1]) begin
      r = x[DATA_W] ? INT_MIN : INT_MAX;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/fsc_ram.sv =====
module fsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fsc_sqrt.sv =====
module fsc_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fsc_pkg::SQ_W-1:0]  radicand,
  output logic                      done,
  output logic [fsc_pkg::ROOT_W-1:0] root
);
  import fsc_pkg::*;

  localparam int RW = ROOT_W + 4;

  logic          busy;
  logic [4:0]    cnt;
  logic [SQ_W-1:0] rad;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;

  // One result bit per cycle, two radicand bits consumed each step.
  assign rem_sh = {rem[RW-3:0], rad[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= rad << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("square root done held for more than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == 5'd0 && !start |=> done && !busy)
    else $error("square root did not finish after its last step");

endmodule

// ===== src/fsc_div.sv =====
module fsc_div #(
  parameter int DW = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [fsc_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [DW-1:0]              quotient
);
  import fsc_pkg::*;

  localparam int CW = $clog2(DW);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   rem_sh;
  logic              fits;

  // Restoring division, one quotient bit per cycle; the quotient shifts in
  // behind the dividend bits as they are consumed.
  assign rem_sh = {rem, quotient[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(DW - 1);
        dvs      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= DATA_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[DATA_W-1:0];
        end
        quotient <= {quotient[DW-2:0], fits};
        cnt      <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("divider remainder not below divisor");

endmodule

// ===== src/frustum_sphere_cull_top.sv =====
// Plane extraction time is set by the bit-serial square root and the divider that runs once
// per plane component; a plane with a zero-length normal skips both and stores zeros.
// Throughput: one item at a time; no new transfer is taken until the last result is loaded.
// Synchronous reset: matrix reads as identity and planes as zero through per-entry valid bits.
module frustum_sphere_cull_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fsc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fsc_pkg::rsp_t rsp
);
  import fsc_pkg::*;

  localparam int QW    = DATA_W + FRACTION_BITS;
  localparam int ACC_W = 2 * DATA_W + 4;
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'sd1 <<< FRACTION_BITS);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_WROW    = 9'b000000010,
    ST_EX_RD   = 9'b000000100,
    ST_EX_SQ   = 9'b000001000,
    ST_EX_SQRT = 9'b000010000,
    ST_EX_DIV  = 9'b000100000,
    ST_EX_ZERO = 9'b001000000,
    ST_TEST    = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state;
  req_t   item;
  rsp_t   rsp_q;

  logic [4:0] cnt;
  logic [2:0] plane;
  logic [1:0] comp;
  logic signed [DATA_W-1:0] v [4];
  logic signed [DATA_W-1:0] base;
  logic signed [ACC_W-1:0]  acc;
  logic signed [2*DATA_W-1:0] prod;
  logic rd_v;
  logic [4:0] rd_k;
  logic mul_v;
  logic mul_last;
  logic outside;
  logic [ROOT_W-1:0] len;
  logic div_go;

  logic [MAT_DEPTH-1:0] mat_valid;
  logic [PL_DEPTH-1:0]  pl_valid;
  logic [31:0]          pl_valid_ext;
  logic mat_vld_q;
  logic mat_diag_q;
  logic pl_vld_q;

  // Memory ports.
  logic              mat_we;
  logic [3:0]        mat_waddr;
  logic [DATA_W-1:0] mat_wdata;
  logic [3:0]        mat_raddr;
  logic [DATA_W-1:0] mat_q;
  logic              pl_we;
  logic [4:0]        pl_waddr;
  logic [DATA_W-1:0] pl_wdata;
  logic [4:0]        pl_raddr;
  logic [DATA_W-1:0] pl_q;

  logic signed [DATA_W-1:0] mat_rd;
  logic signed [DATA_W-1:0] pl_rd;
  logic signed [DATA_W:0]   raw;
  logic issue_rd;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  sq_sum;
  logic signed [ACC_W-1:0]  tot;
  logic signed [ACC_W-1:0]  lim;
  logic [ACC_W-1:0]         rad_sh;

  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     div_quo;
  logic [QW-1:0]     dividend;
  logic              neg;
  logic [DATA_W-1:0] mag;
  logic              big_neg;
  logic              big_pos;
  logic signed [DATA_W-1:0] sat_q;
  logic last_plane_step;

  assign req_stall = (state != ST_IDLE);
  assign rsp       = rsp_q;

  assign issue_rd = (state == ST_EX_RD && cnt < 5'd8) || (state == ST_TEST && cnt < 5'd24);
  assign mat_raddr = {cnt[2:1], cnt[0] ? plane_col(plane) : 2'd3};
  assign pl_raddr  = cnt;
  assign pl_valid_ext = {{(32 - PL_DEPTH){1'b0}}, pl_valid};

  assign mat_rd = mat_vld_q ? $signed(mat_q) : (mat_diag_q ? ONE_Q : '0);
  assign pl_rd  = pl_vld_q ? $signed(pl_q) : '0;

  always_comb begin
    unique case (plane_mode(plane))
      PM_PLUS:  raw = {base[DATA_W-1], base} + {mat_rd[DATA_W-1], mat_rd};
      PM_MINUS: raw = {base[DATA_W-1], base} - {mat_rd[DATA_W-1], mat_rd};
      default:  raw = {mat_rd[DATA_W-1], mat_rd};
    endcase
  end

  // One shared multiplier: squares of the normal during extraction,
  // plane component times centre coordinate, or times one for the offset, during the test.
  always_comb begin
    if (state == ST_EX_SQ) begin
      mul_a = v[cnt[1:0]];
      mul_b = v[cnt[1:0]];
    end else begin
      mul_a = pl_rd;
      unique case (rd_k[1:0])
        2'd0:    mul_b = item.center_x;
        2'd1:    mul_b = item.center_y;
        2'd2:    mul_b = item.center_z;
        default: mul_b = ONE_Q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign sq_sum = acc + ACC_W'(prod);
  assign tot    = acc + ACC_W'(prod);
  assign rad_sh = {{(ACC_W - 31){1'b0}}, item.radius} << FRACTION_BITS;
  assign lim    = -$signed(rad_sh);

  assign sqrt_start = (state == ST_EX_SQ) && (cnt == 5'd3) && (sq_sum != '0);
  assign div_start  = (state == ST_EX_DIV) && div_go;

  assign neg      = v[comp][DATA_W-1];
  assign mag      = neg ? DATA_W'(-v[comp]) : DATA_W'(v[comp]);
  assign dividend = QW'(mag) << FRACTION_BITS;
  assign big_neg  = (|div_quo[QW-1:DATA_W]) || (div_quo[DATA_W-1] && |div_quo[DATA_W-2:0]);
  assign big_pos  = |div_quo[QW-1:DATA_W-1];
  assign sat_q    = neg ? (big_neg ? INT_MIN : -$signed(div_quo[DATA_W-1:0]))
                        : (big_pos ? INT_MAX : $signed(div_quo[DATA_W-1:0]));

  assign mat_we    = (state == ST_WROW);
  assign mat_waddr = {item.row_index, cnt[1:0]};
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    mat_wdata = item.elem_0;
      2'd1:    mat_wdata = item.elem_1;
      2'd2:    mat_wdata = item.elem_2;
      default: mat_wdata = item.elem_3;
    endcase
  end

  assign pl_we    = (state == ST_EX_DIV && div_done) || (state == ST_EX_ZERO);
  assign pl_waddr = {plane, comp};
  assign pl_wdata = (state == ST_EX_ZERO) ? '0 : sat_q;

  assign last_plane_step = (comp == 2'd3) && (plane == 3'(NUM_PLANES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      mat_valid <= '0;
      pl_valid  <= '0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      rd_v       <= issue_rd;
      rd_k       <= cnt;
      mat_vld_q  <= mat_valid[mat_raddr];
      mat_diag_q <= (mat_raddr[3:2] == mat_raddr[1:0]);
      pl_vld_q   <= pl_valid_ext[pl_raddr];
      if (mat_we) begin
        mat_valid[mat_waddr] <= 1'b1;
      end
      if (pl_we) begin
        pl_valid[pl_waddr] <= 1'b1;
      end
      // In ST_DONE the result register is handled by the state itself.
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item    <= req;
            cnt     <= '0;
            plane   <= '0;
            outside <= 1'b0;
            acc     <= '0;
            priority if (req.kind == KIND_ROW) begin
              state <= ST_WROW;
            end else if (req.kind == KIND_EXTRACT) begin
              state <= ST_EX_RD;
            end else if (req.kind == KIND_TEST) begin
              state <= ST_TEST;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_WROW: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            state <= ST_DONE;
          end
        end
        ST_EX_RD: begin
          cnt <= cnt + 5'd1;
          if (rd_v) begin
            if (!rd_k[0]) begin
              base <= mat_rd;
            end else begin
              v[rd_k[2:1]] <= sat33(raw);
            end
          end
          if (cnt == 5'd8) begin
            state <= ST_EX_SQ;
            cnt   <= '0;
            acc   <= '0;
          end
        end
        ST_EX_SQ: begin
          cnt <= cnt + 5'd1;
          if (cnt != 5'd0) begin
            acc <= sq_sum;
          end
          if (cnt == 5'd3) begin
            comp <= '0;
            if (sq_sum == '0) begin
              state <= ST_EX_ZERO;
            end else begin
              state <= ST_EX_SQRT;
            end
          end
        end
        ST_EX_SQRT: begin
          if (sqrt_done) begin
            len    <= sqrt_root;
            div_go <= 1'b1;
            state  <= ST_EX_DIV;
          end
        end
        ST_EX_DIV: begin
          if (div_go) begin
            div_go <= 1'b0;
          end
          if (div_done) begin
            comp <= comp + 2'd1;
            if (comp != 2'd3) begin
              div_go <= 1'b1;
            end else if (last_plane_step) begin
              state <= ST_DONE;
            end else begin
              plane <= plane + 3'd1;
              cnt   <= '0;
              state <= ST_EX_RD;
            end
          end
        end
        ST_EX_ZERO: begin
          comp <= comp + 2'd1;
          if (comp == 2'd3) begin
            if (last_plane_step) begin
              state <= ST_DONE;
            end else begin
              plane <= plane + 3'd1;
              cnt   <= '0;
              state <= ST_EX_RD;
            end
          end
        end
        ST_TEST: begin
          cnt      <= cnt + 5'd1;
          mul_v    <= rd_v;
          mul_last <= (rd_k[1:0] == 2'd3);
          if (mul_v) begin
            if (mul_last) begin
              if (tot < lim) begin
                outside <= 1'b1;
              end
              acc <= '0;
            end else begin
              acc <= tot;
            end
          end
          if (cnt == 5'd25) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp_q.inside_res <= (item.kind == KIND_TEST) ? !outside : 1'b1;
            rsp_q.done_kind  <= item.kind;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  fsc_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  fsc_ram #(.WIDTH(DATA_W), .DEPTH(PL_DEPTH)) u_pl_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_q)
  );

  fsc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_sum[SQ_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  fsc_div #(.DW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_non_test_inside: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_q.done_kind != KIND_TEST |-> rsp_q.inside_res)
    else $error("non-test item reported outside");
  a_pl_write_state: assert property (@(posedge clk) disable iff (rst)
    pl_we |-> (state == ST_EX_DIV || state == ST_EX_ZERO))
    else $error("plane store written outside extraction");
  a_mat_write_state: assert property (@(posedge clk) disable iff (rst)
    mat_we |-> item.kind == KIND_ROW)
    else $error("matrix written by an item that is not a row write");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state != ST_IDLE)
    else $error("transfer in did not start work");
  a_sqrt_done_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_EX_SQRT)
    else $error("square root finished while not awaited");

endmodule
